/* rtl/gtbs_pkg.sv */
// gtbs_pkg: field widths, opcodes and the level clamp for the gamma threshold search
// no dependencies; imported by gamma_table_binary_search
package gtbs_pkg;

  localparam int VALUE_W   = 16;
  localparam int INDEX_W   = 8;
  localparam int LEVEL_W   = 8;
  localparam int LEVEL_MAX = 255;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // clamp a search position to the level range
  function automatic logic [LEVEL_W-1:0] sat_level(input logic [31:0] pos);
    logic [LEVEL_W-1:0] lvl;
    if (pos > 32'(LEVEL_MAX)) begin
      lvl = LEVEL_W'(LEVEL_MAX);
    end else begin
      lvl = pos[LEVEL_W-1:0];
    end
    return lvl;
  endfunction

endpackage

/* rtl/gamma_table_binary_search.sv */
// gamma_table_binary_search: threshold table with a binary-search quantizer
// depends on gtbs_pkg and gtbs_ram
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per item. A beat with
//   in_opcode = write stores in_entry_value at in_entry_index (an index at or
//   above ENTRIES is dropped) and gives no result; writes: one per cycle when idle.
//   A beat with in_opcode = query quantizes in_query_value and gives one beat
//   on the result channel (out_valid / out_stall) with out_level.
//   A query walks the table through one ram read port: it first checks entry 0,
//   then runs the halving steps, ceil(log2(ENTRIES)) steps at most (8 for
//   255 entries). The result is registered from the entry 0 check when the
//   value is at or below entry 0, else from the last halving step; in_stall
//   is high meanwhile, so one query is in flight at a time.
//   A result waiting in the output register does not block the next item; if
//   a new result finishes while the old one is still stalled, it is parked and
//   in_stall stays high until the output register frees up.
//   Reset clears control state only; table entries are undefined until written
//   and every entry must be written before queries are sent.
module gamma_table_binary_search
  import gtbs_pkg::*;
#(
  parameter int ENTRIES = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [INDEX_W-1:0] in_entry_index,
  input  logic [VALUE_W-1:0] in_entry_value,
  input  logic [VALUE_W-1:0] in_query_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] out_level
);

  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] LO_INIT  = CNT_W'(1);
  localparam logic [CNT_W-1:0] HI_INIT  = CNT_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] MID_INIT = CNT_W'(ENTRIES / 2);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [VALUE_W-1:0] query_r, query_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [CNT_W-1:0]   mid_r, mid_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;

  logic               in_acc;
  logic               out_free;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;
  logic [CNT_W:0]     mid_sum;
  logic               done;
  logic [LEVEL_W-1:0] res_level;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

  // table writes, out-of-range indexes dropped
  assign ram_we    = in_acc && (in_opcode == OP_WRITE) && (32'(in_entry_index) < ENTRIES);
  assign ram_waddr = ADDR_W'(in_entry_index);

  gtbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_entry_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry 0 check, then per search cycle one compare, bound update and next probe
  always_comb begin
    state_nxt     = state_r;
    query_nxt     = query_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_level_nxt = out_level_r;
    mid_sum       = '0;
    done          = 1'b0;
    res_level     = '0;
    ram_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_opcode == OP_QUERY)) begin
          query_nxt = in_query_value;
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (query_r <= ram_rdata) begin
          done      = 1'b1;
          res_level = '0;
        end else begin
          lo_nxt    = LO_INIT;
          hi_nxt    = HI_INIT;
          mid_nxt   = MID_INIT;
          ram_raddr = MID_INIT[ADDR_W-1:0];
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (query_r < ram_rdata) begin
          hi_nxt = mid_r - CNT_W'(1);
        end else begin
          lo_nxt = mid_r + CNT_W'(1);
        end
        mid_sum   = {1'b0, lo_nxt} + {1'b0, hi_nxt};
        mid_nxt   = mid_sum[CNT_W:1];
        ram_raddr = mid_nxt[ADDR_W-1:0];
        if (lo_nxt > hi_nxt) begin
          done      = 1'b1;
          res_level = sat_level(32'(lo_nxt));
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hand the result to the output register, or park it
    if (done) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_level_nxt = res_level;
        state_nxt     = ST_IDLE;
      end else begin
        level_nxt = res_level;
        state_nxt = ST_HOLD;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    query_r     <= query_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    level_r     <= level_nxt;
    out_level_r <= out_level_nxt;
  end

  // search bounds stay ordered while probing
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (lo_r <= hi_r))
    else $error("search bounds crossed while probing");

  // probe lies inside the live range
  a_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> ((mid_r >= lo_r) && (mid_r <= hi_r)))
    else $error("probe outside search range");

  // an accepted query starts with the entry 0 check
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_opcode == OP_QUERY)) |=> (state_r == ST_ZERO))
    else $error("query did not start search");

  // a result is parked only while the output register is occupied
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("result parked with free output register");

  // no input beat taken while a search is running
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ZERO) || (state_r == ST_SRCH)) |-> !in_acc)
    else $error("input beat taken during search");

endmodule

/* rtl/gtbs_ram.sv */
// gtbs_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module gtbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 255
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
